### hw/rtl/mvn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvn_pkg: shared types and constants of the vector normaliser
// Item word passed from the front end to the arithmetic back end, and the
// gain scale table.
// ----------------------------------------------------------------------------
package mvn_pkg;

  localparam int MVN_FRAC_BITS = 15;
  localparam int MVN_AXIS_W    = 16;
  localparam int MVN_SUM_W     = 32;
  localparam int MVN_NORM_W    = 16;
  localparam int MVN_SCALE_W   = 9;
  localparam int MVN_MAG_OUT_W = 25;

  localparam logic REG_GAIN_CODE = 1'b0;

  typedef struct packed {
    logic [MVN_AXIS_W-1:0] mag_x;
    logic [MVN_AXIS_W-1:0] mag_y;
    logic [MVN_AXIS_W-1:0] mag_z;
    logic                  neg_x;
    logic                  neg_y;
    logic                  neg_z;
    logic                  zero;
  } mvn_item_t;

  // Hundredths of a milligauss per count for each gain code.
  function automatic logic [MVN_SCALE_W-1:0] mvn_scale(input logic [2:0] code);
    logic [MVN_SCALE_W-1:0] s;
    begin
      case (code)
        3'd0:    s = 9'd73;
        3'd1:    s = 9'd92;
        3'd2:    s = 9'd122;
        3'd3:    s = 9'd152;
        3'd4:    s = 9'd227;
        3'd5:    s = 9'd256;
        3'd6:    s = 9'd303;
        default: s = 9'd435;
      endcase
      return s;
    end
  endfunction

endpackage

### hw/rtl/mvn_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvn_front: input capture
// Takes a raw sample, splits each axis into sign and magnitude and flags the
// zero vector.
// ----------------------------------------------------------------------------
module mvn_front import mvn_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic signed [15:0]    in_raw_x,
  input  logic signed [15:0]    in_raw_y,
  input  logic signed [15:0]    in_raw_z,
  input  logic                  q_full,
  output logic                  busy,
  output logic                  push,
  output mvn_item_t             item
);

  logic      valid_r, valid_nxt;
  mvn_item_t item_r;
  logic      take;

  function automatic logic [15:0] absval(input logic [15:0] v);
    return v[15] ? 16'(-v) : v;
  endfunction

  assign busy = valid_r && q_full;
  assign push = valid_r && !q_full;
  assign take = start && !busy;
  assign item = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (push) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.mag_x <= absval(in_raw_x);
      item_r.mag_y <= absval(in_raw_y);
      item_r.mag_z <= absval(in_raw_z);
      item_r.neg_x <= in_raw_x[15];
      item_r.neg_y <= in_raw_y[15];
      item_r.neg_z <= in_raw_z[15];
      item_r.zero  <= (in_raw_x == 16'sd0) && (in_raw_y == 16'sd0) &&
                      (in_raw_z == 16'sd0);
    end
  end

endmodule

### hw/rtl/mvn_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvn_queue: two-entry item queue
// Decouples the front end from the back end.
// ----------------------------------------------------------------------------
module mvn_queue import mvn_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  mvn_item_t push_item,
  output logic      full,
  output logic      pop,
  output mvn_item_t pop_item
);

  mvn_item_t   mem_r [0:1];
  logic        wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign pop      = (cnt_r != 2'd0);
  assign pop_item = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

endmodule

### hw/rtl/mvn_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvn_back: arithmetic pipeline
// Squares and sum, a digit-per-stage square root, a bit-per-stage divider
// for the three components, then saturation and magnitude scaling.
// ----------------------------------------------------------------------------
module mvn_back import mvn_pkg::*; #(
  parameter int FRAC_BITS = MVN_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  mvn_item_t          in_item,
  input  logic [2:0]         gain_code,
  output logic               out_valid,
  output logic signed [15:0] out_unit_x,
  output logic signed [15:0] out_unit_y,
  output logic signed [15:0] out_unit_z,
  output logic [24:0]        out_field_magnitude,
  output logic               out_zero_vector
);

  localparam int SQ_STG = MVN_NORM_W;
  localparam int DV_STG = FRAC_BITS + 1;
  localparam int QW     = FRAC_BITS + 1;

  // Squares and sum.
  logic              v_sq_r, v_sum_r;
  mvn_item_t         it_sq_r, it_sum_r;
  logic [31:0]       sq_r [0:2];
  logic [MVN_SUM_W-1:0] sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_sq_r  <= 1'b0;
      v_sum_r <= 1'b0;
    end else begin
      v_sq_r  <= in_vld;
      v_sum_r <= v_sq_r;
    end
  end

  always_ff @(posedge clk) begin
    it_sq_r  <= in_item;
    sq_r[0]  <= in_item.mag_x * in_item.mag_x;
    sq_r[1]  <= in_item.mag_y * in_item.mag_y;
    sq_r[2]  <= in_item.mag_z * in_item.mag_z;
    it_sum_r <= it_sq_r;
    sum_r    <= sq_r[0] + sq_r[1] + sq_r[2];
  end

  // Square root, one result bit a stage.
  logic [SQ_STG:0]      sv_r;
  mvn_item_t            sit_r  [0:SQ_STG];
  logic [MVN_SUM_W-1:0] rad_r  [0:SQ_STG];
  logic [16:0]          rem_r  [0:SQ_STG];
  logic [15:0]          root_r [0:SQ_STG];

  assign sv_r[0]   = v_sum_r;
  assign sit_r[0]  = it_sum_r;
  assign rad_r[0]  = sum_r;
  assign rem_r[0]  = '0;
  assign root_r[0] = '0;

  for (genvar k = 0; k < SQ_STG; k++) begin : g_sqrt
    logic [18:0] rsh, trial, diff;
    logic        ge;
    always_comb begin
      rsh   = {rem_r[k], rad_r[k][2*(SQ_STG-1-k)+1 -: 2]};
      trial = {1'b0, root_r[k], 2'b01};
      ge    = (rsh >= trial);
      diff  = rsh - trial;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[k+1] <= 1'b0;
      end else begin
        sv_r[k+1] <= sv_r[k];
      end
    end
    always_ff @(posedge clk) begin
      sit_r[k+1]  <= sit_r[k];
      rad_r[k+1]  <= rad_r[k];
      rem_r[k+1]  <= ge ? diff[16:0] : rsh[16:0];
      root_r[k+1] <= {root_r[k][14:0], ge};
    end
  end

  // Restoring division of mag * 2^FRAC_BITS by the norm, three lanes.
  logic [DV_STG:0] dv_r;
  mvn_item_t       dit_r [0:DV_STG];
  logic [15:0]     dn_r  [0:DV_STG];
  logic [16:0]     dr_r  [0:DV_STG][0:2];
  logic [QW-1:0]   dq_r  [0:DV_STG][0:2];

  assign dv_r[0]     = sv_r[SQ_STG];
  assign dit_r[0]    = sit_r[SQ_STG];
  assign dn_r[0]     = root_r[SQ_STG];
  assign dr_r[0][0]  = {1'b0, sit_r[SQ_STG].mag_x};
  assign dr_r[0][1]  = {1'b0, sit_r[SQ_STG].mag_y};
  assign dr_r[0][2]  = {1'b0, sit_r[SQ_STG].mag_z};
  assign dq_r[0][0]  = '0;
  assign dq_r[0][1]  = '0;
  assign dq_r[0][2]  = '0;

  for (genvar j = 0; j < DV_STG; j++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j+1] <= 1'b0;
      end else begin
        dv_r[j+1] <= dv_r[j];
      end
    end
    always_ff @(posedge clk) begin
      dit_r[j+1] <= dit_r[j];
      dn_r[j+1]  <= dn_r[j];
    end
    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [16:0] t;
      logic        ge;
      always_comb begin
        t  = (j == 0) ? dr_r[j][l] : {dr_r[j][l][15:0], 1'b0};
        ge = (t >= {1'b0, dn_r[j]});
      end
      always_ff @(posedge clk) begin
        dr_r[j+1][l] <= ge ? (t - {1'b0, dn_r[j]}) : t;
        dq_r[j+1][l] <= {dq_r[j][l][QW-2:0], ge};
      end
    end
  end

  // Saturation, sign and scaling.
  localparam logic [QW-1:0] LIMIT = QW'((1 << FRAC_BITS) - 1);

  mvn_item_t   fit;
  logic [15:0] comp [0:2];
  logic        negs [0:2];

  assign fit     = dit_r[DV_STG];
  assign negs[0] = fit.neg_x;
  assign negs[1] = fit.neg_y;
  assign negs[2] = fit.neg_z;

  for (genvar l = 0; l < 3; l++) begin : g_sat
    logic [QW-1:0] sat;
    always_comb begin
      sat     = (dq_r[DV_STG][l] > LIMIT) ? LIMIT : dq_r[DV_STG][l];
      comp[l] = fit.zero ? 16'd0 : (negs[l] ? 16'(-16'(sat)) : 16'(sat));
    end
  end

  // The product needs the full 25 bits, so both operands are widened first.
  logic [24:0] fmag;
  assign fmag = fit.zero ? 25'd0 :
                ({9'd0, dn_r[DV_STG]} * {16'd0, mvn_scale(gain_code)});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dv_r[DV_STG];
    end
  end

  always_ff @(posedge clk) begin
    out_unit_x          <= comp[0];
    out_unit_y          <= comp[1];
    out_unit_z          <= comp[2];
    out_field_magnitude <= fmag;
    out_zero_vector     <= fit.zero;
  end

endmodule

### hw/rtl/magnetometer_vector_normalizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magnetometer_vector_normalizer_top: three-axis field vector normaliser
// Turns a raw magnetometer sample into a Q1.15 unit vector and a scaled
// field magnitude.
// ----------------------------------------------------------------------------
// The pipeline holds the sixteen square-root stages and the FRAC_BITS + 1
// divider stages between start and out_valid.
// Throughput: one word per cycle; the receiver cannot stall, so busy never
// rises in normal use.
// Reset (rst_n, synchronous, active low) empties the pipeline and sets the
// gain code to 1.
// ----------------------------------------------------------------------------
module magnetometer_vector_normalizer_top import mvn_pkg::*; #(
  parameter int FRAC_BITS = MVN_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  // Input channel
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_raw_x,
  input  logic signed [15:0] in_raw_y,
  input  logic signed [15:0] in_raw_z,
  // Result channel
  output logic               out_valid,
  output logic signed [15:0] out_unit_x,
  output logic signed [15:0] out_unit_y,
  output logic signed [15:0] out_unit_z,
  output logic [24:0]        out_field_magnitude,
  output logic               out_zero_vector,
  // Configuration port
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  // The gain code is the only register; it sits at byte address zero.
  logic [2:0] gain_r, gain_nxt;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == REG_GAIN_CODE);
  assign gain_nxt   = cfg_wr ? cfg_pwdata[2:0] : gain_r;
  assign cfg_prdata = (cfg_paddr[2] == REG_GAIN_CODE) ? {29'd0, gain_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= 3'd1;
    end else begin
      gain_r <= gain_nxt;
    end
  end

  // The front end captures a word into its staging register; the queue
  // hands it to the back end, which never stalls because results cannot
  // be held off.
  mvn_item_t f_item, q_item;
  logic      f_push, q_full, q_pop;

  mvn_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_raw_x (in_raw_x),
    .in_raw_y (in_raw_y),
    .in_raw_z (in_raw_z),
    .q_full   (q_full),
    .busy     (busy),
    .push     (f_push),
    .item     (f_item)
  );

  mvn_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_item (f_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_item)
  );

  mvn_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_vld              (q_pop),
    .in_item             (q_item),
    .gain_code           (gain_r),
    .out_valid           (out_valid),
    .out_unit_x          (out_unit_x),
    .out_unit_y          (out_unit_y),
    .out_unit_z          (out_unit_z),
    .out_field_magnitude (out_field_magnitude),
    .out_zero_vector     (out_zero_vector)
  );

endmodule

### tb/mvn_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvn_scoreboard: result checker for the vector normaliser
// Watches the input channel, the result channel and the configuration port,
// predicts each result word and compares it field by field in order.
// ----------------------------------------------------------------------------
module mvn_scoreboard import mvn_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic signed [15:0] in_raw_x,
  input  logic signed [15:0] in_raw_y,
  input  logic signed [15:0] in_raw_z,
  input  logic               out_valid,
  input  logic signed [15:0] out_unit_x,
  input  logic signed [15:0] out_unit_y,
  input  logic signed [15:0] out_unit_z,
  input  logic [24:0]        out_field_magnitude,
  input  logic               out_zero_vector,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  input  logic               cfg_pready,
  output int                 pending,
  output int                 error_count,
  output int                 zero_seen,
  output int                 sat_seen
);

  typedef struct packed {
    logic signed [15:0] ux;
    logic signed [15:0] uy;
    logic signed [15:0] uz;
    logic [24:0]        mag;
    logic               zero;
  } unit_vec_t;

  localparam int COUNTS_SCALE [8] = '{73, 92, 122, 152, 227, 256, 303, 435};

  unit_vec_t   expected_vecs[$];
  logic [2:0]  gain;

  function automatic logic signed [15:0] q15_component(logic signed [15:0] a,
                                                       logic [15:0] n);
    longint mag;
    longint q;
    longint lim;
    begin
      mag = (a < 0) ? -longint'(a) : longint'(a);
      lim = (longint'(1) << MVN_FRAC_BITS) - 1;
      q = (mag << MVN_FRAC_BITS) / n;
      if (q > lim) q = lim;
      if (a < 0) q = -q;
      return q[15:0];
    end
  endfunction

  function automatic unit_vec_t normalise(logic signed [15:0] x, logic signed [15:0] y,
                                          logic signed [15:0] z, logic [2:0] g);
    logic [31:0] sum;
    logic [31:0] trial;
    logic [15:0] root;
    unit_vec_t   r;
    begin
      sum = x * x + y * y + z * z;
      sum = 32'(longint'(x) * x + longint'(y) * y + longint'(z) * z);
      root = '0;
      for (int b = 15; b >= 0; b--) begin
        trial = {16'd0, root | 16'(1 << b)};
        if (trial * trial <= sum) root = trial[15:0];
      end
      r = '0;
      if (sum == 0) begin
        r.zero = 1'b1;
      end else begin
        r.ux  = q15_component(x, root);
        r.uy  = q15_component(y, root);
        r.uz  = q15_component(z, root);
        r.mag = 25'(longint'(root) * COUNTS_SCALE[g]);
      end
      return r;
    end
  endfunction

  always @(posedge clk) begin
    unit_vec_t e;
    if (!rst_n) begin
      gain = 3'd1;
      expected_vecs.delete();
      error_count = 0;
      zero_seen = 0;
      sat_seen = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && (cfg_paddr >> 2) == REG_GAIN_CODE)
        gain = cfg_pwdata[2:0];
      if (start && !busy)
        expected_vecs.push_back(normalise(in_raw_x, in_raw_y, in_raw_z, gain));
      if (out_valid) begin
        if (expected_vecs.size() == 0) begin
          $display("%0t: unexpected result word x=%0d y=%0d z=%0d", $time,
                   out_unit_x, out_unit_y, out_unit_z);
          error_count++;
        end else begin
          e = expected_vecs.pop_front();
          if (out_unit_x !== e.ux || out_unit_y !== e.uy || out_unit_z !== e.uz ||
              out_field_magnitude !== e.mag || out_zero_vector !== e.zero) begin
            $display("%0t: mismatch expected x=%0d y=%0d z=%0d mag=%0d zero=%0b", $time,
                     e.ux, e.uy, e.uz, e.mag, e.zero);
            $display("%0t:          actual   x=%0d y=%0d z=%0d mag=%0d zero=%0b", $time,
                     out_unit_x, out_unit_y, out_unit_z, out_field_magnitude,
                     out_zero_vector);
            error_count++;
          end
          if (e.zero) zero_seen++;
          if (e.ux == 16'sd32767 || e.ux == -16'sd32767) sat_seen++;
        end
      end
    end
    pending = expected_vecs.size();
  end

endmodule

### tb/magnetometer_vector_normalizer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magnetometer_vector_normalizer_top_tb: testbench of the vector normaliser
// Drives directed and random raw samples under every gain code, with random
// gaps on the input side, and leaves all checking to the scoreboard.
// ----------------------------------------------------------------------------
module magnetometer_vector_normalizer_top_tb;
  import mvn_pkg::*;

  // The pipeline is FRAC_BITS + 22 deep; this drain allows for it with room.
  localparam int DRAIN_CYCLES = 60;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [15:0] in_raw_x, in_raw_y, in_raw_z;
  logic               out_valid;
  logic signed [15:0] out_unit_x, out_unit_y, out_unit_z;
  logic [24:0]        out_field_magnitude;
  logic               out_zero_vector;
  logic               cfg_psel, cfg_penable, cfg_pwrite;
  logic [2:0]         cfg_paddr;
  logic [31:0]        cfg_pwdata;
  logic [31:0]        cfg_prdata;
  logic               cfg_pready;

  int pending, error_count, zero_seen, sat_seen;
  int words_sent;
  bit no_gaps;

  magnetometer_vector_normalizer_top i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_raw_x(in_raw_x), .in_raw_y(in_raw_y), .in_raw_z(in_raw_z),
    .out_valid(out_valid), .out_unit_x(out_unit_x), .out_unit_y(out_unit_y),
    .out_unit_z(out_unit_z), .out_field_magnitude(out_field_magnitude),
    .out_zero_vector(out_zero_vector),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  mvn_scoreboard i_scoreboard (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_raw_x(in_raw_x), .in_raw_y(in_raw_y), .in_raw_z(in_raw_z),
    .out_valid(out_valid), .out_unit_x(out_unit_x), .out_unit_y(out_unit_y),
    .out_unit_z(out_unit_z), .out_field_magnitude(out_field_magnitude),
    .out_zero_vector(out_zero_vector),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_pready(cfg_pready),
    .pending(pending), .error_count(error_count), .zero_seen(zero_seen),
    .sat_seen(sat_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Safety net: the whole run needs well under a tenth of this time.
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Presents one sample word. With probability of about 22 in a hundred a
  // short gap is inserted first, unless the current stretch runs gap-free.
  // The word is accepted at the first edge at which busy was low; busy is
  // read straight after the edge, before the block's own updates land.
  task automatic send_sample(input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic signed [15:0] z);
    if (!no_gaps && $urandom_range(99) < 22) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_raw_x <= x;
    in_raw_y <= y;
    in_raw_z <= z;
    start    <= 1'b1;
    do @(posedge clk); while (busy);
    words_sent++;
  endtask

  // Lets the pipeline empty completely so that the gain code can change
  // without affecting a word in flight.
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Two-phase register write: setup cycle, then access cycle.
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Random sample with a bias towards the interesting shapes: full-range
  // noise, small vectors, single-axis vectors (which saturate), all-extreme corners and zeros.
  task automatic send_random();
    logic signed [15:0] x, y, z;
    int shape;
    shape = $urandom_range(99);
    x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
    if (shape < 15) begin
      x = $signed(16'($urandom_range(15))) - 16'sd8;
      y = $signed(16'($urandom_range(15))) - 16'sd8;
      z = $signed(16'($urandom_range(15))) - 16'sd8;
    end else if (shape < 25) begin
      case ($urandom_range(2))
        0:       begin y = 0; z = 0; end
        1:       begin x = 0; z = 0; end
        default: begin x = 0; y = 0; end
      endcase
    end else if (shape < 28) begin
      x = 0; y = 0; z = 0;
    end else if (shape < 35) begin
      x = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      y = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      z = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
    end
    send_sample(x, y, z);
  endtask

  initial begin
    words_sent  = 0;
    no_gaps     = 1'b0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_raw_x    = '0;
    in_raw_y    = '0;
    in_raw_z    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words under the reset gain code: zero vector, each axis at
    // full scale in both signs (the saturating case), the all-extreme
    // corners, and a few ordinary vectors.
    send_sample(0, 0, 0);
    send_sample(16'sh7fff, 0, 0);
    send_sample(16'sh8000, 0, 0);
    send_sample(0, 16'sh7fff, 0);
    send_sample(0, 16'sh8000, 0);
    send_sample(0, 0, 16'sh7fff);
    send_sample(0, 0, 16'sh8000);
    send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000);
    send_sample(16'sh8000, 16'sh7fff, 16'sh8000);
    send_sample(1, 0, 0);
    send_sample(-1, -1, -1);
    send_sample(3, -4, 0);
    send_sample(100, 200, -300);
    send_sample(-12345, 6789, 31000);
    wait_idle();

    // Only the lowest three bits of the gain code are kept, and a write to
    // an address beyond the single register must change nothing.
    write_reg(3'd0, 32'hffff_fff8);
    write_reg(3'd4, 32'h0000_0007);
    send_sample(16'sh7fff, 16'sh8000, 16'sh7fff);
    send_sample(1000, -2000, 3000);
    wait_idle();
    write_reg(3'd0, 32'h0000_0007);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000);
    send_sample(0, 0, 0);
    send_sample(-500, 700, 900);
    wait_idle();

    // Random phases, one per gain code in a shuffled order; the third
    // phase runs without gaps and the fifth pauses midway until empty.
    for (int phase = 0; phase < 8; phase++) begin
      write_reg(3'd0, {29'($urandom_range(32'h1fff_ffff)), 3'(phase * 5 + 2)});
      no_gaps = (phase == 2);
      for (int k = 0; k < 220; k++) begin
        if (phase == 4 && k == 110) begin
          start <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        send_random();
      end
      wait_idle();
    end
    no_gaps = 1'b0;

    $display("Sent %0d sample words over all eight gain codes, with gaps and a gap-free run.",
             words_sent);
    $display("Checked %0d zero vectors and %0d saturated X components.", zero_seen, sat_seen);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
